// File: rtl/tspc_pkg.sv
// ----------------------------------------------------------------------------
// Shutter controller package
// Shared widths, item structs, command codes and the position estimate
// function for the timed shutter position controller.
// ----------------------------------------------------------------------------
package tspc_pkg;

  // Width of every position, target and elapsed-time value, in milliseconds.
  localparam int unsigned POSITION_BITS = 18;

  // Full travel time after reset and the matching tenth of travel.
  localparam logic [POSITION_BITS-1:0] FULL_TRAVEL_RESET = POSITION_BITS'(20000);
  localparam logic [POSITION_BITS-1:0] TENTH_RESET       =
    POSITION_BITS'(FULL_TRAVEL_RESET / 10);

  // Division by ten as a multiply by a rounded-up reciprocal and a shift.
  // With four spare fraction bits the result is exact for every input value.
  localparam int unsigned TENTH_SHIFT = POSITION_BITS + 4;
  localparam int unsigned TENTH_PROD_BITS = 2 * POSITION_BITS + 4;
  localparam longint unsigned TenthRecipL = ((64'd1 << TENTH_SHIFT) + 64'd9) / 64'd10;
  localparam logic [POSITION_BITS:0] TENTH_RECIP = (POSITION_BITS + 1)'(TenthRecipL);

  // Item modes.
  localparam logic MODE_TICK   = 1'b0;
  localparam logic MODE_REMOTE = 1'b1;

  // Remote command codes.
  localparam logic [3:0] RC_NONE        = 4'd0;
  localparam logic [3:0] RC_HOME        = 4'd1;
  localparam logic [3:0] RC_STOP        = 4'd2;
  localparam logic [3:0] RC_TOP         = 4'd3;
  localparam logic [3:0] RC_BOTTOM      = 4'd4;
  localparam logic [3:0] RC_TENTH_FIRST = 4'd5;
  localparam logic [3:0] RC_TENTH_LAST  = 4'd13;
  // A tenths code minus this base gives the number of tenths.
  localparam logic [3:0] RC_TENTH_BASE  = 4'd4;

  // Button actions.
  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_SHORT = 2'd1;
  localparam logic [1:0] ACT_LONG  = 2'd2;

  // Motion codes as shown on the result.
  localparam logic [1:0] MOTION_IDLE    = 2'd0;
  localparam logic [1:0] MOTION_CLOSING = 2'd1;
  localparam logic [1:0] MOTION_OPENING = 2'd2;
  localparam logic [1:0] MOTION_HOMING  = 2'd3;

  // Motor state machine, one-hot.
  typedef enum logic [3:0] {
    MV_IDLE  = 4'b0001,
    MV_CLOSE = 4'b0010,
    MV_OPEN  = 4'b0100,
    MV_HOME  = 4'b1000
  } move_e;

  // One input item.
  typedef struct packed {
    logic       mode;
    logic [3:0] remote_code;
    logic [1:0] up_action;
    logic [1:0] down_action;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic                     open_drive;
    logic                     close_drive;
    logic [1:0]               motion;
    logic [POSITION_BITS-1:0] estimated_position;
    logic [POSITION_BITS-1:0] target_position;
  } out_item_t;

  // Position estimate from the stored position and the drive time so far.
  // The drive time is limited to full travel before it is used.
  function automatic logic [POSITION_BITS-1:0] estimate(
    input move_e                    ms,
    input logic [POSITION_BITS-1:0] stored,
    input logic [POSITION_BITS-1:0] elapsed,
    input logic [POSITION_BITS-1:0] full
  );
    logic [POSITION_BITS-1:0] e;
    logic [POSITION_BITS:0]   sum;
    logic [POSITION_BITS-1:0] res;
    e   = (elapsed < full) ? elapsed : full;
    sum = {1'b0, stored} + {1'b0, e};
    unique case (ms)
      MV_HOME:  res = full - e;
      MV_CLOSE: res = (sum > {1'b0, full}) ? full : sum[POSITION_BITS-1:0];
      MV_OPEN:  res = (stored > e) ? (stored - e) : '0;
      default:  res = stored;
    endcase
    return res;
  endfunction

endpackage

// File: rtl/timed_shutter_position_controller.sv
// ----------------------------------------------------------------------------
// Timed shutter position controller
// Drives a shutter motor without a position sensor, estimating the position
// from drive time in milliseconds (zero is fully open).
// Input channel in_valid_i/in_ready_o/in_data_i carries one item per
// transfer: a one millisecond tick with button actions, or a remote command.
// Output channel out_valid_o/out_ready_i/out_data_o returns exactly one
// result per item: drive lines, motion, estimated and target position.
// An accepted item waits in the input register and its result goes to the
// result register; one item is taken every cycle while the receiver does
// not stall, set by the single step of the control logic between them.
// When the receiver stalls, the result register holds and one more item
// waits in the input register; then in_ready_o drops.
// Reset clears both registers, stops the motor at position zero and loads
// a full travel time of 20000 ms. cfg_we_i/cfg_wdata_i write the full
// travel time at once; write only while no item is in flight.
// ----------------------------------------------------------------------------
module timed_shutter_position_controller (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  tspc_pkg::in_item_t                 in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output tspc_pkg::out_item_t                out_data_o,
  input  logic                               cfg_we_i,
  input  logic [tspc_pkg::POSITION_BITS-1:0] cfg_wdata_i
);

  logic                               in_valid_q;
  tspc_pkg::in_item_t                 in_data_q;
  logic                               out_valid_q;
  tspc_pkg::out_item_t                out_data_q;
  logic                               advance;
  logic [tspc_pkg::POSITION_BITS-1:0] full;
  logic [tspc_pkg::POSITION_BITS-1:0] tenth;
  tspc_pkg::out_item_t                result;

  // The held item moves on when the result register is free or drains.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  // Configuration register.
  tspc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .full_o      (full),
    .tenth_o     (tenth)
  );

  // Control state and step logic.
  tspc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (in_data_q),
    .full_i   (full),
    .tenth_i  (tenth),
    .result_o (result)
  );

  // Input register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_data_q <= in_data_i;
    end
  end

  // Result register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// File: rtl/tspc_cfg.sv
// ----------------------------------------------------------------------------
// Shutter controller configuration register
// Holds the full travel time and a tenth of it, which is worked out by a
// reciprocal multiply in the cycle of the write.
// ----------------------------------------------------------------------------
module tspc_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tspc_pkg::POSITION_BITS-1:0] cfg_wdata_i,
  output logic [tspc_pkg::POSITION_BITS-1:0] full_o,
  output logic [tspc_pkg::POSITION_BITS-1:0] tenth_o
);

  logic [tspc_pkg::POSITION_BITS-1:0]   full_q;
  logic [tspc_pkg::POSITION_BITS-1:0]   tenth_q;
  logic [tspc_pkg::POSITION_BITS-1:0]   tenth_d;
  logic [tspc_pkg::TENTH_PROD_BITS-1:0] tenth_prod;

  // Tenth of the written value: multiply by the reciprocal, keep the high bits.
  assign tenth_prod = tspc_pkg::TENTH_PROD_BITS'(cfg_wdata_i)
                    * tspc_pkg::TENTH_PROD_BITS'(tspc_pkg::TENTH_RECIP);
  assign tenth_d    = tenth_prod[tspc_pkg::TENTH_SHIFT +: tspc_pkg::POSITION_BITS];

  // Register update on a write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q  <= tspc_pkg::FULL_TRAVEL_RESET;
      tenth_q <= tspc_pkg::TENTH_RESET;
    end else if (cfg_we_i) begin
      full_q  <= cfg_wdata_i;
      tenth_q <= tenth_d;
    end
  end

  assign full_o  = full_q;
  assign tenth_o = tenth_q;

endmodule

// File: rtl/tspc_ctrl.sv
// ----------------------------------------------------------------------------
// Shutter controller state and step logic
// Holds the motor state and position estimate and applies one item per
// step: tick with button actions or remote command.
// ----------------------------------------------------------------------------
module tspc_ctrl (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               step_i,
  input  tspc_pkg::in_item_t                 item_i,
  input  logic [tspc_pkg::POSITION_BITS-1:0] full_i,
  input  logic [tspc_pkg::POSITION_BITS-1:0] tenth_i,
  output tspc_pkg::out_item_t                result_o
);

  localparam int unsigned PB = tspc_pkg::POSITION_BITS;

  // State registers.
  logic [PB-1:0]       stored_q, stored_d;
  logic [PB-1:0]       target_q, target_d;
  logic [PB-1:0]       elapsed_q, elapsed_d;
  tspc_pkg::move_e     ms_q, ms_d;
  logic [3:0]          lr_q, lr_d;

  // Tick path signals.
  logic [PB-1:0]       el_tick;
  logic [PB-1:0]       ev_tick;
  logic                stop_tick;
  tspc_pkg::move_e     ms1;
  logic [PB-1:0]       stored1;
  logic [3:0]          lr1;
  logic                req_home, req_open, req_close, any_req;
  logic                is_tick;

  // Positioning move signals.
  logic [PB-1:0]       ev_rem;
  logic [PB-1:0]       stored_a, el_a, ev_a;
  logic [3:0]          lr_a;
  logic [3:0]          tenth_count;
  logic [PB+3:0]       tenth_prod;
  logic [PB-1:0]       goto_p;
  logic                pre_halt;
  logic [PB-1:0]       goto_stored, goto_target, goto_el;
  tspc_pkg::move_e     goto_ms;
  logic [3:0]          goto_lr;
  logic                goto_fresh;
  logic                fresh_move;
  logic [PB-1:0]       est_final;

  // Advance the drive time and check whether the move has reached its target.
  always_comb begin
    el_tick = (elapsed_q < full_i) ? (elapsed_q + PB'(1)) : full_i;
    ev_tick = tspc_pkg::estimate(ms_q, stored_q, el_tick, full_i);
    unique case (ms_q)
      tspc_pkg::MV_HOME:  stop_tick = (ev_tick == '0);
      tspc_pkg::MV_CLOSE: stop_tick = (ev_tick >= target_q);
      tspc_pkg::MV_OPEN:  stop_tick = (ev_tick <= target_q);
      default:            stop_tick = 1'b0;
    endcase
    ms1     = stop_tick ? tspc_pkg::MV_IDLE : ms_q;
    stored1 = stop_tick ? ev_tick : stored_q;
    lr1     = stop_tick ? tspc_pkg::RC_NONE : lr_q;
  end

  // Estimate before the item, as seen by a remote command.
  assign ev_rem = tspc_pkg::estimate(ms_q, stored_q, elapsed_q, full_i);

  // Button requests: long up homes, short up opens, a down push closes if up is not pushed.
  always_comb begin
    req_home  = (item_i.up_action == tspc_pkg::ACT_LONG);
    req_open  = (item_i.up_action == tspc_pkg::ACT_SHORT);
    req_close = !req_home && !req_open
              && ((item_i.down_action == tspc_pkg::ACT_SHORT)
               || (item_i.down_action == tspc_pkg::ACT_LONG));
    any_req   = req_home || req_open || req_close;
    is_tick   = (item_i.mode == tspc_pkg::MODE_TICK);
  end

  // Target of a positioning move.
  assign tenth_count = item_i.remote_code - tspc_pkg::RC_TENTH_BASE;
  assign tenth_prod  = {4'b0, tenth_i} * {PB'(0), tenth_count};

  always_comb begin
    if (is_tick) begin
      goto_p = req_open ? '0 : full_i;
    end else begin
      unique case (item_i.remote_code) inside
        tspc_pkg::RC_TOP:    goto_p = '0;
        tspc_pkg::RC_BOTTOM: goto_p = full_i;
        default:             goto_p = tenth_prod[PB-1:0];
      endcase
    end
  end

  // Positioning move: stop first if the last move is unfinished, then drive
  // toward the new position or settle if already there. A tick only starts
  // a move from idle, where the estimate is the stored position.
  always_comb begin
    stored_a = is_tick ? stored1 : stored_q;
    el_a     = is_tick ? el_tick : elapsed_q;
    lr_a     = is_tick ? lr1 : lr_q;
    ev_a     = is_tick ? stored1 : ev_rem;
    pre_halt = (target_q != stored_a);

    goto_stored = pre_halt ? ev_a : stored_a;
    goto_lr     = pre_halt ? tspc_pkg::RC_NONE : lr_a;
    if (goto_p > goto_stored) begin
      goto_target = goto_p;
      goto_el     = '0;
      goto_ms     = tspc_pkg::MV_CLOSE;
      goto_fresh  = 1'b1;
    end else if (goto_p < goto_stored) begin
      goto_target = goto_p;
      goto_el     = '0;
      goto_ms     = tspc_pkg::MV_OPEN;
      goto_fresh  = 1'b1;
    end else begin
      goto_target = target_q;
      goto_el     = el_a;
      goto_ms     = tspc_pkg::MV_IDLE;
      goto_lr     = tspc_pkg::RC_NONE;
      goto_fresh  = 1'b0;
    end
  end

  // Next state for one item.
  always_comb begin
    stored_d   = stored_q;
    target_d   = target_q;
    elapsed_d  = elapsed_q;
    ms_d       = ms_q;
    lr_d       = lr_q;
    fresh_move = 1'b0;
    if (is_tick) begin
      stored_d  = stored1;
      elapsed_d = el_tick;
      ms_d      = ms1;
      lr_d      = lr1;
      if (any_req) begin
        if (ms1 != tspc_pkg::MV_IDLE) begin
          // A button push while moving only stops the motor.
          stored_d = ev_tick;
          ms_d     = tspc_pkg::MV_IDLE;
          lr_d     = tspc_pkg::RC_NONE;
        end else if (req_home) begin
          target_d   = '0;
          stored_d   = full_i;
          elapsed_d  = '0;
          ms_d       = tspc_pkg::MV_HOME;
          fresh_move = 1'b1;
        end else begin
          stored_d   = goto_stored;
          target_d   = goto_target;
          elapsed_d  = goto_el;
          ms_d       = goto_ms;
          lr_d       = goto_lr;
          fresh_move = goto_fresh;
        end
      end
    end else if (item_i.remote_code != lr_q) begin
      // A remote code equal to the last one is ignored.
      unique case (item_i.remote_code) inside
        tspc_pkg::RC_HOME: begin
          lr_d       = tspc_pkg::RC_HOME;
          target_d   = '0;
          stored_d   = full_i;
          elapsed_d  = '0;
          ms_d       = tspc_pkg::MV_HOME;
          fresh_move = 1'b1;
        end
        tspc_pkg::RC_STOP: begin
          stored_d = ev_a;
          ms_d     = tspc_pkg::MV_IDLE;
          lr_d     = tspc_pkg::RC_NONE;
        end
        tspc_pkg::RC_TOP, tspc_pkg::RC_BOTTOM,
        [tspc_pkg::RC_TENTH_FIRST:tspc_pkg::RC_TENTH_LAST]: begin
          stored_d   = goto_stored;
          target_d   = goto_target;
          elapsed_d  = goto_el;
          ms_d       = goto_ms;
          lr_d       = item_i.remote_code;
          fresh_move = goto_fresh;
        end
        default: begin
          lr_d = lr_q;
        end
      endcase
    end
  end

  // Result fields from the state after the item. An idle motor or a move
  // that starts now sits at its stored position; a running move keeps the
  // estimate already worked out for this item.
  always_comb begin
    if ((ms_d == tspc_pkg::MV_IDLE) || fresh_move) begin
      est_final = stored_d;
    end else if (is_tick) begin
      est_final = ev_tick;
    end else begin
      est_final = ev_rem;
    end
    result_o.open_drive  = (ms_d == tspc_pkg::MV_OPEN) || (ms_d == tspc_pkg::MV_HOME);
    result_o.close_drive = (ms_d == tspc_pkg::MV_CLOSE);
    unique case (ms_d)
      tspc_pkg::MV_CLOSE: result_o.motion = tspc_pkg::MOTION_CLOSING;
      tspc_pkg::MV_OPEN:  result_o.motion = tspc_pkg::MOTION_OPENING;
      tspc_pkg::MV_HOME:  result_o.motion = tspc_pkg::MOTION_HOMING;
      default:            result_o.motion = tspc_pkg::MOTION_IDLE;
    endcase
    result_o.estimated_position = est_final;
    result_o.target_position    = target_d;
  end

  // State update, one item per step.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stored_q  <= '0;
      target_q  <= '0;
      elapsed_q <= '0;
      ms_q      <= tspc_pkg::MV_IDLE;
      lr_q      <= tspc_pkg::RC_NONE;
    end else if (step_i) begin
      stored_q  <= stored_d;
      target_q  <= target_d;
      elapsed_q <= elapsed_d;
      ms_q      <= ms_d;
      lr_q      <= lr_d;
    end
  end

endmodule

// File: rtl/tspc_checker.sv
// ----------------------------------------------------------------------------
// Shutter controller port checker
// Watches the top-level ports for handshake, latency and result coherence.
// ----------------------------------------------------------------------------
module tspc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input tspc_pkg::out_item_t out_data_o
);

  // A stalled result holds its value until the transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("result changed while stalled");

  // Every accepted item shows a valid result once it has passed both registers.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |-> ##2 out_valid_o)
    else $error("no result two cycles after an input transfer");

  // The input side only backs up behind a stalled result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input not ready without an output stall");

  // Drive lines agree with the reported motion.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (out_data_o.close_drive == (out_data_o.motion == tspc_pkg::MOTION_CLOSING))
      && (out_data_o.open_drive == ((out_data_o.motion == tspc_pkg::MOTION_OPENING)
                                 || (out_data_o.motion == tspc_pkg::MOTION_HOMING))))
    else $error("drive lines do not match motion");

endmodule

bind timed_shutter_position_controller tspc_checker u_tspc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// File: dv/shutter_status_checker.sv
// ----------------------------------------------------------------------------
// Shutter status checker
// Watches both channels and the travel-time register of the shutter
// controller. It keeps its own model of the motor, predicts the status
// report for every input transfer, and compares each output transfer with
// the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module shutter_status_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic                               in_ready_i,
  input  tspc_pkg::in_item_t                 in_data_i,
  input  logic                               out_valid_i,
  input  logic                               out_ready_i,
  input  tspc_pkg::out_item_t                out_data_i,
  input  logic                               cfg_we_i,
  input  logic [tspc_pkg::POSITION_BITS-1:0] cfg_wdata_i,
  output int                                 fail_count_o,
  output int                                 reports_pending_o
);
  import tspc_pkg::*;

  typedef logic [POSITION_BITS-1:0] pos_t;

  localparam int unsigned TENTHS_PER_TRAVEL = 10;

  // Model of the motor: travel time, stored position, target, drive time.
  pos_t       full_ms;
  pos_t       stored_ms;
  pos_t       target_ms;
  pos_t       elapsed_ms;
  move_e      motor;
  logic [3:0] last_cmd;

  // Status reports predicted but not yet seen on the output.
  out_item_t  status_q[$];
  out_item_t  want;
  int         errors;

  // Current position from the stored position and the drive time so far.
  function automatic pos_t position_now();
    pos_t                   run;
    logic [POSITION_BITS:0] reach;
    run   = (elapsed_ms < full_ms) ? elapsed_ms : full_ms;
    reach = {1'b0, stored_ms} + {1'b0, run};
    if (motor == MV_HOME) return full_ms - run;
    if (motor == MV_CLOSE) return (reach > {1'b0, full_ms}) ? full_ms : pos_t'(reach);
    if (motor == MV_OPEN) return (stored_ms > run) ? stored_ms - run : '0;
    return stored_ms;
  endfunction

  // Stopping latches the position and forgets the last remote command.
  function automatic void stop_motor();
    stored_ms = position_now();
    motor     = MV_IDLE;
    last_cmd  = RC_NONE;
  endfunction

  function automatic void start_homing();
    target_ms  = '0;
    stored_ms  = full_ms;
    elapsed_ms = '0;
    motor      = MV_HOME;
  endfunction

  // Positioning stops a move in progress, then heads for the new spot.
  function automatic void move_to(input pos_t dest);
    if (target_ms != stored_ms) stop_motor();
    if (dest > stored_ms) begin
      target_ms  = dest;
      elapsed_ms = '0;
      motor      = MV_CLOSE;
    end else if (dest < stored_ms) begin
      target_ms  = dest;
      elapsed_ms = '0;
      motor      = MV_OPEN;
    end else begin
      motor    = MV_IDLE;
      last_cmd = RC_NONE;
    end
  endfunction

  // Applies one input item to the model and returns the status it causes.
  function automatic out_item_t shutter_step(input in_item_t it);
    out_item_t                rep;
    pos_t                     now;
    logic [POSITION_BITS+3:0] spot;
    logic                     press;
    if (it.mode == MODE_TICK) begin
      if (elapsed_ms < full_ms) elapsed_ms = elapsed_ms + 1'b1;
      else elapsed_ms = full_ms;
      now = position_now();
      if (motor == MV_HOME && now == '0) stop_motor();
      else if (motor == MV_CLOSE && now >= target_ms) stop_motor();
      else if (motor == MV_OPEN && now <= target_ms) stop_motor();
      // Up wins over down; the unused action code counts as no push.
      press = (it.up_action == ACT_LONG) || (it.up_action == ACT_SHORT) ||
              (it.down_action == ACT_LONG) || (it.down_action == ACT_SHORT);
      if (press) begin
        if (motor != MV_IDLE) stop_motor();
        else if (it.up_action == ACT_LONG) start_homing();
        else if (it.up_action == ACT_SHORT) move_to('0);
        else move_to(full_ms);
      end
    end else if (it.remote_code != last_cmd) begin
      if (it.remote_code == RC_HOME) begin
        last_cmd = it.remote_code;
        start_homing();
      end else if (it.remote_code == RC_STOP) begin
        stop_motor();
      end else if (it.remote_code == RC_TOP) begin
        move_to('0);
        last_cmd = it.remote_code;
      end else if (it.remote_code == RC_BOTTOM) begin
        move_to(full_ms);
        last_cmd = it.remote_code;
      end else if (it.remote_code >= RC_TENTH_FIRST && it.remote_code <= RC_TENTH_LAST) begin
        spot = (it.remote_code - RC_TENTH_BASE) * (full_ms / TENTHS_PER_TRAVEL);
        move_to(pos_t'(spot));
        last_cmd = it.remote_code;
      end
    end
    rep.open_drive  = (motor == MV_OPEN) || (motor == MV_HOME);
    rep.close_drive = (motor == MV_CLOSE);
    case (motor)
      MV_CLOSE: rep.motion = MOTION_CLOSING;
      MV_OPEN:  rep.motion = MOTION_OPENING;
      MV_HOME:  rep.motion = MOTION_HOMING;
      default:  rep.motion = MOTION_IDLE;
    endcase
    rep.estimated_position = position_now();
    rep.target_position    = target_ms;
    return rep;
  endfunction

  task automatic compare_field(input string field, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
      errors++;
    end
  endtask

  // Track register writes and both channels at every rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_ms    = FULL_TRAVEL_RESET;
      stored_ms  = '0;
      target_ms  = '0;
      elapsed_ms = '0;
      motor      = MV_IDLE;
      last_cmd   = RC_NONE;
      status_q.delete();
      errors     = 0;
      fail_count_o      <= 0;
      reports_pending_o <= 0;
    end else begin
      if (cfg_we_i) full_ms = cfg_wdata_i;
      // Each output transfer is matched against the oldest prediction.
      if (out_valid_i && out_ready_i) begin
        if (status_q.size() == 0) begin
          $display("%0t: unexpected status transfer, expected none, actual %p",
                   $time, out_data_i);
          errors++;
        end else begin
          want = status_q.pop_front();
          compare_field("open_drive", want.open_drive, out_data_i.open_drive);
          compare_field("close_drive", want.close_drive, out_data_i.close_drive);
          compare_field("motion", want.motion, out_data_i.motion);
          compare_field("estimated_position", want.estimated_position,
                        out_data_i.estimated_position);
          compare_field("target_position", want.target_position,
                        out_data_i.target_position);
        end
      end
      if (in_valid_i && in_ready_i) status_q.push_back(shutter_step(in_data_i));
      fail_count_o      <= errors;
      reports_pending_o <= status_q.size();
    end
  end

endmodule

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// Shutter controller testbench
// Drives ticks with button pushes and remote commands into the timed shutter
// position controller under several travel times, with random gaps on both
// channels, and leaves prediction and comparison to the status checker.
// ----------------------------------------------------------------------------
module tb;
  import tspc_pkg::*;

  typedef logic [POSITION_BITS-1:0] pos_t;

  // Codes the block treats as no command or no push.
  localparam logic [3:0] RC_UNUSED_LOW  = 4'd14;
  localparam logic [3:0] RC_UNUSED_HIGH = 4'd15;
  localparam logic [1:0] ACT_UNUSED     = 2'd3;

  localparam pos_t        TRAVEL_MIN  = 10;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned DRAIN_TAIL  = 4;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_we    = 1'b0;
  pos_t      cfg_wdata = '0;

  int          fail_count;
  int          reports_pending;
  int unsigned tx_idle_pct  = 15;
  int unsigned rx_idle_pct  = 73;
  int unsigned event_pct    = 10;
  int unsigned quiet_cycles = 0;

  always #5 clk = ~clk;

  timed_shutter_position_controller uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  shutter_status_checker u_check (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_ready_i        (in_ready),
    .in_data_i         (in_data),
    .out_valid_i       (out_valid),
    .out_ready_i       (out_ready),
    .out_data_i        (out_data),
    .cfg_we_i          (cfg_we),
    .cfg_wdata_i       (cfg_wdata),
    .fail_count_o      (fail_count),
    .reports_pending_o (reports_pending)
  );

  // The receiver stalls at random according to the current idle rate.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Watchdog: too many cycles without any transfer ends the run.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic in_item_t tick_item(input logic [1:0] up, input logic [1:0] down);
    in_item_t it;
    it.mode        = MODE_TICK;
    it.remote_code = RC_UNUSED_HIGH;
    it.up_action   = up;
    it.down_action = down;
    return it;
  endfunction

  function automatic in_item_t remote_item(input logic [3:0] code);
    in_item_t it;
    it.mode        = MODE_REMOTE;
    it.remote_code = code;
    it.up_action   = ACT_UNUSED;
    it.down_action = ACT_UNUSED;
    return it;
  endfunction

  // Mostly quiet ticks so that moves can run to their end; the rest are
  // button pushes and remote commands, mostly with meaningful codes.
  function automatic in_item_t random_item();
    in_item_t it;
    it.mode        = MODE_TICK;
    it.remote_code = 4'($urandom_range(15));
    it.up_action   = 2'($urandom_range(3));
    it.down_action = 2'($urandom_range(3));
    if ($urandom_range(99) < event_pct) begin
      if ($urandom_range(2) == 0) begin
        it.mode = MODE_REMOTE;
        if ($urandom_range(9) != 0) it.remote_code = 4'($urandom_range(RC_HOME, RC_TENTH_LAST));
      end
    end else begin
      it.up_action   = ACT_NONE;
      it.down_action = ACT_NONE;
    end
    return it;
  endfunction

  // One input transfer, after a random number of idle cycles.
  task automatic send(input in_item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Hold off the sender until every predicted status has been seen.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (reports_pending != 0);
  endtask

  // Change the full travel time while nothing is in flight.
  task automatic set_travel(input pos_t ms);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= ms;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random items, with the event rate redrawn every twenty items.
  task automatic random_run(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 20 == 0) begin
        case ($urandom_range(2))
          0:       event_pct = 2;
          1:       event_pct = 15;
          default: event_pct = 45;
        endcase
      end
      send(random_item());
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: a few commands at the reset travel time.
    send(remote_item(RC_TENTH_LAST));
    send(tick_item(ACT_NONE, ACT_NONE));
    send(remote_item(RC_STOP));

    // Directed: every push and command at the shortest travel time.
    set_travel(TRAVEL_MIN);
    send(tick_item(ACT_SHORT, ACT_LONG));
    send(tick_item(ACT_NONE, ACT_SHORT));
    send(tick_item(ACT_LONG, ACT_LONG));
    send(tick_item(ACT_LONG, ACT_NONE));
    send(remote_item(RC_HOME));
    send(remote_item(RC_HOME));
    send(remote_item(RC_NONE));
    send(remote_item(RC_UNUSED_LOW));
    send(remote_item(RC_UNUSED_HIGH));
    send(remote_item(RC_BOTTOM));
    send(remote_item(RC_TOP));
    send(remote_item(RC_TENTH_FIRST));
    send(remote_item(RC_TENTH_LAST));
    send(remote_item(RC_STOP));
    send(tick_item(ACT_UNUSED, ACT_UNUSED));
    send(tick_item(ACT_UNUSED, ACT_LONG));

    // Sender idles lightly, receiver heavily.
    random_run(160);
    drain();
    random_run(160);
    set_travel(97);
    random_run(300);

    // Sender idles heavily, receiver lightly.
    tx_idle_pct = 73;
    rx_idle_pct <= 15;
    set_travel('1);
    random_run(150);
    set_travel(23);
    random_run(350);

    // No idling on either side.
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    set_travel(50);
    random_run(350);
    set_travel(TRAVEL_MIN);
    random_run(350);

    drain();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (fail_count == 0 && reports_pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
